[design/srs_pkg.sv]
`default_nettype none

package srs_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int IDX_W       = $clog2(MAX_RECORDS);

	localparam int ID_W    = 34;
	localparam int SCORE_W = 7;
	localparam int AGE_W   = 7;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
		logic [AGE_W-1:0]   age;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CLOSE,
		ST_RD0,
		ST_FIRST,
		ST_CMP,
		ST_TAIL,
		ST_DRAIN_RD,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic store_in;
		logic clear_set;
		logic pass_init;
		logic rd_first;
		logic take_first;
		logic cmp_step;
		logic tail_write;
		logic drain_start;
		logic drain_load;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic n_lt2;
		logic k_at_end;
		logic end_is_one;
		logic drain_at_end;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

[design/srs_in_if.sv]
`default_nettype none

interface srs_in_if;
	logic                         valid;
	logic                         ready;
	logic [srs_pkg::ID_W-1:0]     record_id;
	logic [srs_pkg::SCORE_W-1:0]  score;
	logic [srs_pkg::AGE_W-1:0]    age_value;
	logic                         is_last;

	modport source (output valid, output record_id, output score, output age_value,
		output is_last, input ready);
	modport sink (input valid, input record_id, input score, input age_value,
		input is_last, output ready);
endinterface

`default_nettype wire

[design/srs_out_if.sv]
`default_nettype none

interface srs_out_if;
	logic                         valid;
	logic                         ready;
	logic [srs_pkg::ID_W-1:0]     out_id;
	logic [srs_pkg::SCORE_W-1:0]  out_score;
	logic [srs_pkg::AGE_W-1:0]    out_age;
	logic                         out_last;
	logic                         overflow;

	modport source (output valid, output out_id, output out_score, output out_age,
		output out_last, output overflow, input ready);
	modport sink (input valid, input out_id, input out_score, input out_age,
		input out_last, input overflow, output ready);
endinterface

`default_nettype wire

[design/srs_ram.sv]
`default_nettype none

module srs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/srs_ctrl.sv]
`default_nettype none

module srs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_is_last,
	input  wire srs_pkg::status_t  status,
	output      logic              in_ready,
	output      srs_pkg::cmd_t     cmd
);

	srs_pkg::state_t state_q, state_d;
	logic            accept;

	assign accept = in_valid && (state_q == srs_pkg::ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srs_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srs_pkg::ST_LOAD: begin
				if (accept && in_is_last) state_d = srs_pkg::ST_CLOSE;
			end
			srs_pkg::ST_CLOSE: begin
				priority if (status.n_zero) state_d = srs_pkg::ST_LOAD;
				else if (status.n_lt2)      state_d = srs_pkg::ST_DRAIN_RD;
				else                        state_d = srs_pkg::ST_RD0;
			end
			srs_pkg::ST_RD0:   state_d = srs_pkg::ST_FIRST;
			srs_pkg::ST_FIRST: state_d = srs_pkg::ST_CMP;
			srs_pkg::ST_CMP: begin
				if (status.k_at_end) state_d = srs_pkg::ST_TAIL;
			end
			srs_pkg::ST_TAIL: begin
				state_d = status.end_is_one ? srs_pkg::ST_DRAIN_RD : srs_pkg::ST_RD0;
			end
			srs_pkg::ST_DRAIN_RD: state_d = srs_pkg::ST_DRAIN;
			srs_pkg::ST_DRAIN: begin
				if (status.out_free && status.drain_at_end) state_d = srs_pkg::ST_LOAD;
			end
			default: state_d = srs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			srs_pkg::ST_LOAD: begin
				in_ready     = 1'b1;
				cmd.store_in = accept;
			end
			srs_pkg::ST_CLOSE: begin
				cmd.clear_set = status.n_zero;
				cmd.pass_init = !status.n_zero && !status.n_lt2;
			end
			srs_pkg::ST_RD0:      cmd.rd_first    = 1'b1;
			srs_pkg::ST_FIRST:    cmd.take_first  = 1'b1;
			srs_pkg::ST_CMP:      cmd.cmp_step    = 1'b1;
			srs_pkg::ST_TAIL:     cmd.tail_write  = 1'b1;
			srs_pkg::ST_DRAIN_RD: cmd.drain_start = 1'b1;
			srs_pkg::ST_DRAIN:    cmd.drain_load  = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[design/srs_dp.sv]
`default_nettype none

module srs_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire srs_pkg::cmd_t     cmd,
	output      srs_pkg::status_t  status,
	srs_in_if.sink                 rec_in,
	srs_out_if.source              rec_out,
	input  wire logic              in_ready
);

	localparam int CW = srs_pkg::CNT_W;
	localparam int IW = srs_pkg::IDX_W;

	logic [CW-1:0]     record_count_q;
	logic              dropped_q;
	logic [IW-1:0]     k_q;
	logic [IW-1:0]     end_q;
	logic [IW-1:0]     drain_idx_q;
	srs_pkg::rec_t     carry_q;

	logic              out_valid_q;
	srs_pkg::rec_t     out_rec_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic              full;
	logic              swap;
	logic              drain_take;
	logic              set_done;
	srs_pkg::rec_t     in_rec;
	srs_pkg::rec_t     rdata;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	srs_pkg::rec_t     ram_wdata;
	logic              ram_re;
	logic [IW-1:0]     ram_raddr;

	assign in_rec = '{id: rec_in.record_id, score: rec_in.score, age: rec_in.age_value};
	assign rec_in.ready = in_ready;

	assign full = (record_count_q == CW'(srs_pkg::MAX_RECORDS));
	// only a strictly greater score moves forward, which keeps equal scores in order
	assign swap = (carry_q.score > rdata.score);

	assign status.n_zero       = (record_count_q == '0);
	assign status.n_lt2        = (record_count_q < CW'(2));
	assign status.k_at_end     = (k_q == end_q);
	assign status.end_is_one   = (end_q == IW'(1));
	assign status.drain_at_end = ((CW'(drain_idx_q) + CW'(1)) == record_count_q);
	assign status.out_free     = !out_valid_q || rec_out.ready;

	assign drain_take = cmd.drain_load && status.out_free;
	assign set_done   = cmd.clear_set || (drain_take && status.drain_at_end);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		priority if (cmd.rd_first || cmd.drain_start) begin
			ram_re = 1'b1;
		end else if (cmd.take_first) begin
			ram_re    = 1'b1;
			ram_raddr = k_q;
		end else if (cmd.cmp_step && !status.k_at_end) begin
			ram_re    = 1'b1;
			ram_raddr = k_q + IW'(1);
		end else if (drain_take && !status.drain_at_end) begin
			ram_re    = 1'b1;
			ram_raddr = drain_idx_q + IW'(1);
		end else begin
			ram_re = 1'b0;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = in_rec;
		priority if (cmd.store_in && !full) begin
			ram_we    = 1'b1;
			ram_waddr = record_count_q[IW-1:0];
		end else if (cmd.cmp_step) begin
			// the smaller of the carried and fetched records settles one slot back
			ram_we    = 1'b1;
			ram_waddr = k_q - IW'(1);
			ram_wdata = swap ? rdata : carry_q;
		end else if (cmd.tail_write) begin
			ram_we    = 1'b1;
			ram_waddr = end_q;
			ram_wdata = carry_q;
		end else begin
			ram_we = 1'b0;
		end
	end

	srs_ram #(
		.WIDTH (srs_pkg::REC_W),
		.DEPTH (srs_pkg::MAX_RECORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_count_q <= '0;
			dropped_q      <= 1'b0;
			k_q            <= '0;
			end_q          <= '0;
			drain_idx_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (set_done) begin
				record_count_q <= '0;
				dropped_q      <= 1'b0;
			end else if (cmd.store_in) begin
				if (full) dropped_q <= 1'b1;
				else record_count_q <= record_count_q + CW'(1);
			end

			if (cmd.rd_first) begin
				k_q <= IW'(1);
			end else if (cmd.cmp_step && !status.k_at_end) begin
				k_q <= k_q + IW'(1);
			end

			if (cmd.pass_init) begin
				end_q <= IW'(record_count_q - CW'(1));
			end else if (cmd.tail_write) begin
				end_q <= end_q - IW'(1);
			end

			if (cmd.drain_start) begin
				drain_idx_q <= '0;
			end else if (drain_take && !status.drain_at_end) begin
				drain_idx_q <= drain_idx_q + IW'(1);
			end

			if (drain_take) begin
				out_valid_q <= 1'b1;
			end else if (rec_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_first) begin
			carry_q <= rdata;
		end else if (cmd.cmp_step) begin
			carry_q <= swap ? carry_q : rdata;
		end
		if (drain_take) begin
			out_rec_q  <= rdata;
			out_last_q <= status.drain_at_end;
			out_ovf_q  <= dropped_q;
		end
	end

	assign rec_out.valid     = out_valid_q;
	assign rec_out.out_id    = out_rec_q.id;
	assign rec_out.out_score = out_rec_q.score;
	assign rec_out.out_age   = out_rec_q.age;
	assign rec_out.out_last  = out_last_q;
	assign rec_out.overflow  = out_ovf_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		record_count_q <= CW'(srs_pkg::MAX_RECORDS))
		else $error("record count beyond capacity");

	a_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp_step |-> (k_q != '0) && (k_q <= end_q))
		else $error("compare index outside the pass");

	a_tail_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tail_write |-> end_q != '0)
		else $error("pass end underflow");

	a_drain_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_load |-> CW'(drain_idx_q) < record_count_q)
		else $error("drain index past stored records");

	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_take && status.drain_at_end) |=> record_count_q == '0 && !dropped_q)
		else $error("set state not cleared after last item");
`endif

endmodule

`default_nettype wire

[design/stable_record_sorter.sv]
// Channel   Dir  Payload                                        Moves when
// rec_in    in   record_id, score, age_value, is_last           valid && ready
// rec_out   out  out_id, out_score, out_age, out_last, overflow valid && ready
//
// Loading: one item per cycle until the item with is_last set, then a closing state.
// Sort: one compare per cycle over the n stored records,
// bounded by the single read and single write port of the record store.
// Drain: a read state to start, then one item per cycle while rec_out is ready.
// rec_in is ready only while loading; the last output item may wait while the next set loads.
// Reset clears the counters, flags and state; the store itself is not cleared.
`default_nettype none

module stable_record_sorter (
	input  wire logic  clk,
	input  wire logic  arst_n,
	srs_in_if.sink     rec_in,
	srs_out_if.source  rec_out
);

	srs_pkg::cmd_t    cmd;
	srs_pkg::status_t status;
	logic             in_ready;

	srs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rec_in.valid),
		.in_is_last (rec_in.is_last),
		.status     (status),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	srs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.rec_in   (rec_in),
		.rec_out  (rec_out),
		.in_ready (in_ready)
	);

endmodule

`default_nettype wire

[verif/srs_order_checker.sv]
`default_nettype none

module srs_order_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	srs_in_if         rec_in,
	srs_out_if        rec_out,
	output int        mismatch_count,
	output int        pending_results
);

	typedef struct packed {
		srs_pkg::rec_t rec;
		logic          last;
		logic          dropped;
	} sorted_item_t;

	sorted_item_t  sorted_q[$];
	sorted_item_t  want;
	srs_pkg::rec_t held[srs_pkg::MAX_RECORDS];
	int            held_count;
	logic          set_dropped;
	int            fail_tally;

	// insertion sort, strict compare keeps equal scores in arrival order
	function automatic void sort_held_by_score();
		srs_pkg::rec_t key;
		int            j;
		for (int i = 1; i < held_count; i++) begin
			key = held[i];
			j   = i;
			while (j > 0 && held[j-1].score > key.score) begin
				held[j] = held[j-1];
				j--;
			end
			held[j] = key;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count      = 0;
			set_dropped     = 1'b0;
			fail_tally      = 0;
			sorted_q.delete();
			mismatch_count  <= 0;
			pending_results <= 0;
		end else begin
			if (rec_out.valid && rec_out.ready) begin
				if (sorted_q.size() == 0) begin
					fail_tally++;
					if (fail_tally <= 10)
						$display("checker: unexpected item id %0d score %0d age %0d last %0b",
							rec_out.out_id, rec_out.out_score, rec_out.out_age,
							rec_out.out_last);
				end else begin
					want = sorted_q.pop_front();
					if (rec_out.out_id !== want.rec.id || rec_out.out_score !== want.rec.score
						|| rec_out.out_age !== want.rec.age || rec_out.out_last !== want.last
						|| rec_out.overflow !== want.dropped) begin
						fail_tally++;
						if (fail_tally <= 10)
							$display({"checker: mismatch: expected id %0d score %0d age %0d ",
								"last %0b ovf %0b, got id %0d score %0d age %0d last %0b ovf %0b"},
								want.rec.id, want.rec.score, want.rec.age, want.last,
								want.dropped, rec_out.out_id, rec_out.out_score,
								rec_out.out_age, rec_out.out_last, rec_out.overflow);
					end
				end
			end
			if (rec_in.valid && rec_in.ready) begin
				if (held_count < srs_pkg::MAX_RECORDS) begin
					held[held_count] = '{id: rec_in.record_id, score: rec_in.score,
						age: rec_in.age_value};
					held_count++;
				end else begin
					set_dropped = 1'b1;
				end
				if (rec_in.is_last) begin
					sort_held_by_score();
					for (int k = 0; k < held_count; k++)
						sorted_q.push_back('{rec: held[k], last: (k == held_count - 1),
							dropped: set_dropped});
					held_count  = 0;
					set_dropped = 1'b0;
				end
			end
			mismatch_count  <= fail_tally;
			pending_results <= sorted_q.size();
		end
	end

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   pending_results;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   rx_hold_left;
	int   stall_cycles;

	srs_in_if  rec_in();
	srs_out_if rec_out();

	stable_record_sorter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec_in  (rec_in),
		.rec_out (rec_out)
	);

	srs_order_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.rec_in          (rec_in),
		.rec_out         (rec_out),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random ready, or a counted hold-off when requested
	initial begin
		rec_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				rec_out.ready <= 1'b0;
				rx_hold_left--;
			end else begin
				rec_out.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rec_in.valid && rec_in.ready) || (rec_out.valid && rec_out.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic srs_pkg::rec_t random_record();
		srs_pkg::rec_t r;
		logic [63:0]   wide;
		wide = {$urandom(), $urandom()};
		if ($urandom_range(1, 0) != 0)
			r.id = wide[srs_pkg::ID_W-1:0];
		else
			r.id = srs_pkg::ID_W'(wide % 64'd10000000000);
		case ($urandom_range(9, 0))
			6, 7:    r.score = srs_pkg::SCORE_W'($urandom_range(43, 40));
			8:       r.score = srs_pkg::SCORE_W'($urandom_range(127, 101));
			9:       r.score = srs_pkg::SCORE_W'($urandom_range(127, 0));
			default: r.score = srs_pkg::SCORE_W'($urandom_range(100, 0));
		endcase
		if ($urandom_range(6, 0) != 0)
			r.age = srs_pkg::AGE_W'($urandom_range(120, 18));
		else
			r.age = srs_pkg::AGE_W'($urandom_range(127, 0));
		return r;
	endfunction

	// valid stays high from one item to the next; it drops only on an idle cycle
	task automatic send_record(input srs_pkg::rec_t r, input logic last);
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			rec_in.valid <= 1'b0;
			@(posedge clk);
		end
		rec_in.valid     <= 1'b1;
		rec_in.record_id <= r.id;
		rec_in.score     <= r.score;
		rec_in.age_value <= r.age;
		rec_in.is_last   <= last;
		@(posedge clk);
		while (!rec_in.ready)
			@(posedge clk);
	endtask

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++)
			send_record(random_record(), i == n - 1);
	endtask

	task automatic wait_drained();
		rec_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	initial begin
		int big_size[3];
		int items_sent;
		int set_idx;
		int n;
		big_size = '{64, 65, 70};
		arst_n           <= 1'b0;
		rec_in.valid     <= 1'b0;
		rec_in.record_id <= '0;
		rec_in.score     <= '0;
		rec_in.age_value <= '0;
		rec_in.is_last   <= 1'b0;
		tx_idle_pct  = 7;
		rx_idle_pct  = 73;
		rx_hold_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single record, all-ones id and out-of-range score and age
		send_record(srs_pkg::rec_t'{id: {srs_pkg::ID_W{1'b1}}, score: 7'd127, age: 7'd127},
			1'b1);
		// ties at both ends of the score range must keep arrival order
		send_record(srs_pkg::rec_t'{id: 34'd0, score: 7'd100, age: 7'd18}, 1'b0);
		send_record(srs_pkg::rec_t'{id: 34'd1, score: 7'd0, age: 7'd120}, 1'b0);
		send_record(srs_pkg::rec_t'{id: 34'd2, score: 7'd50, age: 7'd0}, 1'b0);
		send_record(srs_pkg::rec_t'{id: 34'd3, score: 7'd0, age: 7'd127}, 1'b0);
		send_record(srs_pkg::rec_t'{id: 34'd4, score: 7'd100, age: 7'd60}, 1'b0);
		send_record(srs_pkg::rec_t'{id: 34'd9999999999, score: 7'd127, age: 7'd18}, 1'b1);
		for (int i = 0; i < 4; i++)
			send_record(srs_pkg::rec_t'{id: srs_pkg::ID_W'(10 + i), score: 7'd77,
				age: srs_pkg::AGE_W'(30 + i)}, i == 3);
		for (int i = 0; i < 5; i++)
			send_record(srs_pkg::rec_t'{id: srs_pkg::ID_W'(20 + i),
				score: srs_pkg::SCORE_W'(100 - 25 * i), age: 7'd40}, i == 4);
		send_record(srs_pkg::rec_t'{id: 34'd30, score: 7'd1, age: 7'd50}, 1'b0);
		send_record(srs_pkg::rec_t'{id: 34'd31, score: 7'd2, age: 7'd51}, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin tx_idle_pct = 7;  rx_idle_pct = 73; end
				1:       begin tx_idle_pct = 73; rx_idle_pct = 7;  end
				default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
			endcase
			items_sent = 0;
			set_idx    = 0;
			while (items_sent < 110) begin
				if (set_idx == 3)
					n = big_size[phase];
				else if ($urandom_range(3, 0) == 0)
					n = $urandom_range(24, 13);
				else
					n = $urandom_range(12, 1);
				// long output stall while the next set keeps coming
				if (set_idx == 1 && phase != 1)
					rx_hold_left = 400;
				send_set(n);
				items_sent += n;
				set_idx++;
				if (set_idx != 2 && $urandom_range(4, 0) == 0)
					wait_drained();
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
